### rtl/core/infix_expression_evaluator_assert.svh
// Assertion macros shared by the evaluator checker.
// Depends on nothing; included by the checker file.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define IEE_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define IEE_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### rtl/core/iee_pkg.sv
// Package for the infix expression evaluator: codes, types and constants.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package iee_pkg;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    KIND_OPERAND = 3'd0,
    KIND_OPERATOR = 3'd1,
    KIND_LPAREN = 3'd2,
    KIND_RPAREN = 3'd3,
    KIND_END = 3'd4
  } kind_t;

  localparam logic [2:0] PAREN_MARK = 3'd4;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_RDWAIT, S_LHS, S_APPLY, S_MULW, S_DIVW,
    S_WRITE, S_FINISH, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    GOAL_OPERATOR, GOAL_RPAREN, GOAL_END
  } goal_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_tok;
    logic push_val;
    logic push_op;
    logic pop_op;
    logic rd_tops;
    logic start_mul;
    logic start_div;
    logic apply;
    logic write_res;
    logic set_err;
    logic [1:0] err_code;
    logic clear;
    logic emit;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] op;
    logic [2:0] top_op;
    logic [1:0] code;
    logic op_empty;
    logic op_full;
    logic val_full;
    logic val_lt2;
    logic val_empty;
    logic rhs_zero;
    logic mul_done;
    logic div_done;
    logic [1:0] err;
  } sts_t;
endpackage

### rtl/core/iee_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module iee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/iee_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Does not use iee_pkg; depends on nothing.
`timescale 1ns / 1ps
module iee_divider #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

### rtl/core/iee_datapath.sv
// Datapath: token register, stacks, arithmetic unit and result register.
// Depends on iee_pkg, iee_ram and iee_divider.
`timescale 1ns / 1ps
module iee_datapath #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [1:0]         in_op,
  input  iee_pkg::ctl_t      ctl,
  output iee_pkg::sts_t      sts,
  output logic signed [31:0] res_out,
  output logic [1:0]         status_out
);
  import iee_pkg::*;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;

  logic [2:0] kind_r;
  logic [1:0] op_r;
  logic signed [31:0] val_r;
  logic [CW-1:0] opc_r, opc_nxt, valc_r, valc_nxt;
  logic [1:0] err_r, err_nxt;
  logic [2:0] opmem_q;
  logic [31:0] vmem_q;
  logic signed [31:0] lhs_r, rhs_r, res_r;
  logic [1:0] code_r;
  logic vwe, owe;
  logic [AW-1:0] vwaddr, owaddr, vraddr, oraddr;
  logic [31:0] vwdata;
  logic [2:0] owdata;
  logic [31:0] mag_l, mag_r;
  logic [63:0] prod_r;
  logic [NUM_W-1:0] quo;
  logic div_done;
  logic mul_done_r;
  logic neg;
  logic signed [63:0] wide, mag_s;
  logic [63:0] mag_u;
  logic signed [31:0] out_r;
  logic [1:0] stat_r;
  logic rd_phase_r;

  assign neg = lhs_r[31] ^ rhs_r[31];
  assign mag_l = lhs_r[31] ? 32'(-lhs_r) : 32'(lhs_r);
  assign mag_r = rhs_r[31] ? 32'(-rhs_r) : 32'(rhs_r);

  // Two reads in successive cycles: rhs at count-1, then lhs at count-2.
  assign vraddr = ctl.rd_tops ? AW'(valc_r - CW'(2)) : AW'(valc_r - CW'(1));
  assign oraddr = AW'(opc_r - CW'(1));

  assign owe = ctl.push_op;
  assign owaddr = AW'(opc_r);
  assign owdata = (kind_r == KIND_LPAREN) ? PAREN_MARK : {1'b0, op_r};
  assign vwe = ctl.push_val || ctl.write_res;
  assign vwaddr = ctl.push_val ? AW'(valc_r) : AW'(valc_r - CW'(2));
  assign vwdata = ctl.push_val ? val_r : res_r;

  iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_vram (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr), .rdata(vmem_q)
  );
  iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
    .clk(clk), .we(owe), .waddr(owaddr), .wdata(owdata), .raddr(oraddr), .rdata(opmem_q)
  );
  iee_divider #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.start_div),
    .num(NUM_W'({mag_l, {FRAC_BITS{1'b0}}} >> 0)), .den(mag_r), .done(div_done), .quo(quo)
  );

  always_comb begin
    mag_u = '0;
    wide = '0;
    case (code_r)
      OP_ADD: wide = 64'(lhs_r) + 64'(rhs_r);
      OP_SUB: wide = 64'(lhs_r) - 64'(rhs_r);
      OP_MUL: mag_u = prod_r >> FRAC_BITS;
      default: mag_u = 64'(quo);
    endcase
    if (code_r == OP_MUL || code_r == OP_DIV) begin
      mag_s = (mag_u > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag_u);
      wide = neg ? -mag_s : mag_s;
    end else begin
      mag_s = '0;
    end
  end

  always_comb begin
    opc_nxt = opc_r;
    valc_nxt = valc_r;
    err_nxt = err_r;
    if (ctl.push_val) valc_nxt = valc_r + 1'b1;
    if (ctl.push_op) opc_nxt = opc_r + 1'b1;
    if (ctl.pop_op) opc_nxt = opc_r - 1'b1;
    if (ctl.write_res) valc_nxt = valc_r - 1'b1;
    if (ctl.set_err && err_r == ST_OK) err_nxt = ctl.err_code;
    if (ctl.clear) begin
      opc_nxt = '0;
      valc_nxt = '0;
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_r <= '0;
      valc_r <= '0;
      err_r <= ST_OK;
      rd_phase_r <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      opc_r <= opc_nxt;
      valc_r <= valc_nxt;
      err_r <= err_nxt;
      rd_phase_r <= ctl.rd_tops;
      mul_done_r <= ctl.start_mul;
    end
    if (ctl.load_tok) begin
      kind_r <= in_kind;
      op_r <= in_op;
      val_r <= in_value;
    end
    if (ctl.rd_tops) begin
      code_r <= opmem_q[1:0];
      rhs_r <= vmem_q;
    end
    if (rd_phase_r) lhs_r <= vmem_q;
    if (ctl.start_mul) prod_r <= 64'(mag_l) * 64'(mag_r);
    if (ctl.apply) res_r <= (wide > QMAX) ? 32'h7FFF_FFFF : (wide < QMIN) ? 32'h8000_0000 : wide[31:0];
    if (ctl.emit) begin
      stat_r <= err_r;
      out_r <= (err_r != ST_OK) ? 32'sd0 : vmem_q;
    end
  end

  assign sts.kind = kind_r;
  assign sts.op = op_r;
  assign sts.top_op = opmem_q;
  assign sts.code = code_r;
  assign sts.op_empty = (opc_r == '0);
  assign sts.op_full = (opc_r >= CW'(STACK_DEPTH));
  assign sts.val_full = (valc_r >= CW'(STACK_DEPTH));
  assign sts.val_lt2 = (valc_r < CW'(2));
  assign sts.val_empty = (valc_r == '0);
  assign sts.rhs_zero = (rhs_r == 32'sd0);
  assign sts.mul_done = mul_done_r;
  assign sts.div_done = div_done;
  assign sts.err = err_r;
  assign res_out = out_r;
  assign status_out = stat_r;
endmodule

### rtl/core/iee_ctrl.sv
// Controller state machine: sequences pushes, operator application and end.
// Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_free,
  input  iee_pkg::sts_t sts,
  output iee_pkg::ctl_t ctl,
  output logic          in_ready,
  output logic          emit_pulse
);
  import iee_pkg::*;
  state_t state_r, state_nxt;
  goal_t goal_r, goal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      goal_r <= GOAL_END;
    end else begin
      state_r <= state_nxt;
      goal_r <= goal_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    goal_nxt = goal_r;
    ctl = '0;
    in_ready = 1'b0;
    emit_pulse = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load_tok = in_fire;
        if (in_fire) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (sts.kind == KIND_END) begin
          goal_nxt = GOAL_END;
          state_nxt = S_RD;
        end else if (sts.err == ST_OK) begin
          case (sts.kind)
            KIND_OPERAND: begin
              ctl.set_err = sts.val_full;
              ctl.err_code = ST_OVER;
              ctl.push_val = !sts.val_full;
            end
            KIND_LPAREN: begin
              ctl.set_err = sts.op_full;
              ctl.err_code = ST_OVER;
              ctl.push_op = !sts.op_full;
            end
            KIND_OPERATOR: begin
              goal_nxt = GOAL_OPERATOR;
              state_nxt = S_RD;
            end
            KIND_RPAREN: begin
              goal_nxt = GOAL_RPAREN;
              state_nxt = S_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: state_nxt = S_RDWAIT;
      S_RDWAIT: begin
        if (sts.err != ST_OK || sts.op_empty) begin
          if (goal_r == GOAL_END) state_nxt = S_FINISH;
          else if (sts.err != ST_OK) state_nxt = S_IDLE;
          else if (goal_r == GOAL_RPAREN) begin
            ctl.set_err = 1'b1;
            ctl.err_code = ST_UNDER;
            state_nxt = S_IDLE;
          end else begin
            ctl.set_err = sts.op_full;
            ctl.err_code = ST_OVER;
            ctl.push_op = !sts.op_full;
            state_nxt = S_IDLE;
          end
        end else if (sts.top_op == PAREN_MARK) begin
          if (goal_r == GOAL_OPERATOR) begin
            ctl.set_err = sts.op_full;
            ctl.err_code = ST_OVER;
            ctl.push_op = !sts.op_full;
            state_nxt = S_IDLE;
          end else begin
            ctl.pop_op = 1'b1;
            state_nxt = (goal_r == GOAL_END) ? S_RD : S_IDLE;
          end
        end else if (goal_r == GOAL_OPERATOR && sts.top_op[1] < sts.op[1]) begin
          ctl.set_err = sts.op_full;
          ctl.err_code = ST_OVER;
          ctl.push_op = !sts.op_full;
          state_nxt = S_IDLE;
        end else begin
          ctl.pop_op = 1'b1;
          if (sts.val_lt2) begin
            ctl.set_err = 1'b1;
            ctl.err_code = ST_UNDER;
            state_nxt = (goal_r == GOAL_END) ? S_FINISH : S_IDLE;
          end else begin
            ctl.rd_tops = 1'b1;
            state_nxt = S_LHS;
          end
        end
      end
      S_LHS: state_nxt = S_APPLY;
      S_APPLY: begin
        if (sts.code == OP_MUL) begin
          ctl.start_mul = 1'b1;
          state_nxt = S_MULW;
        end else if (sts.code == OP_DIV) begin
          if (sts.rhs_zero) begin
            ctl.set_err = 1'b1;
            ctl.err_code = ST_DIVZ;
            state_nxt = (goal_r == GOAL_END) ? S_FINISH : S_IDLE;
          end else begin
            ctl.start_div = 1'b1;
            state_nxt = S_DIVW;
          end
        end else begin
          ctl.apply = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_MULW: begin
        if (sts.mul_done) begin
          ctl.apply = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          ctl.apply = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.write_res = 1'b1;
        state_nxt = S_RD;
      end
      S_FINISH: begin
        if (sts.err == ST_OK && sts.val_empty) begin
          ctl.set_err = 1'b1;
          ctl.err_code = ST_UNDER;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          ctl.clear = 1'b1;
          emit_pulse = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### rtl/core/infix_expression_evaluator.sv
// Flow: an operand or left paren is loaded, then pushed; an operator or right paren first
// reads the operator stack, then each applied operator reads both operands, computes (multiply
// via the product register, divide via the one-bit-per-cycle divider) and writes back.
// End drains the operator stack, waits for a free output register, then emits one result.
// Synchronous active-low reset clears counts, error code and the result valid.
// Stack contents are not reset; only entries below the counts are used.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // kind[2:0], value[34:3], op[36:35], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // result[31:0], status[33:32], zeros
);
  import iee_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic in_fire, emit_pulse, rdy, ov_r;
  logic signed [31:0] res;
  logic [1:0] stat;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = rdy;

  iee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!ov_r || out_tready),
    .sts(sts), .ctl(ctl), .in_ready(rdy), .emit_pulse(emit_pulse)
  );
  iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_kind(in_tdata[2:0]), .in_value(in_tdata[34:3]),
    .in_op(in_tdata[36:35]), .ctl(ctl), .sts(sts), .res_out(res), .status_out(stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_pulse) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, stat, res};
endmodule

### rtl/core/iee_checker.sv
// Port-level checker for the evaluator, bound to the top level.
// Depends on infix_expression_evaluator_assert.svh.
`timescale 1ns / 1ps
`include "infix_expression_evaluator_assert.svh"
module iee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `IEE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `IEE_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tdata[33:32] != 2'd0, out_tdata[31:0] == 32'd0)
  `IEE_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0)
  `IEE_ASSERT_NXT(a_busy_after, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind infix_expression_evaluator iee_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

### test/tb.sv
// Self-checking testbench for infix_expression_evaluator: streams infix tokens in,
// predicts each end result in-bench and compares it. Depends on iee_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import iee_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [1:0]  op;
  } token_t;

  typedef struct {
    logic [31:0] result;
    logic [1:0]  status;
  } answer_t;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;

  token_t pending_tokens[$];
  answer_t expected_answers[$];
  int n_errors = 0;
  int n_accepted = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  logic [2:0] op_stk[DEPTH];
  longint val_stk[DEPTH];
  int op_n = 0;
  int val_n = 0;
  logic [1:0] err_code = ST_OK;

  infix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  task automatic raise_err(logic [1:0] code);
    if (err_code == ST_OK) err_code = code;
  endtask

  task automatic apply_operator();
    logic [2:0] code;
    longint lhs, rhs, res;
    longint unsigned m;
    bit neg;
    code = op_stk[op_n - 1];
    op_n--;
    if (val_n < 2) begin
      raise_err(ST_UNDER);
      return;
    end
    rhs = val_stk[val_n - 1];
    lhs = val_stk[val_n - 2];
    neg = (lhs < 0) != (rhs < 0);
    case (code[1:0])
      OP_ADD: res = sat32(lhs + rhs);
      OP_SUB: res = sat32(lhs - rhs);
      OP_MUL: begin
        m = (mag64(lhs) * mag64(rhs)) >> FRAC;
        res = sat32(neg ? -longint'(m) : longint'(m));
      end
      default: begin
        if (rhs == 0) begin
          raise_err(ST_DIVZ);
          return;
        end
        m = (mag64(lhs) << FRAC) / mag64(rhs);
        res = sat32(neg ? -longint'(m) : longint'(m));
      end
    endcase
    val_n--;
    val_stk[val_n - 1] = res;
  endtask

  task automatic evaluate_token(token_t t);
    answer_t a;
    longint res;
    res = 0;
    if (t.kind == KIND_END) begin
      while (err_code == ST_OK && op_n > 0) begin
        if (op_stk[op_n - 1] == PAREN_MARK) op_n--;
        else apply_operator();
      end
      if (err_code == ST_OK) begin
        if (val_n == 0) raise_err(ST_UNDER);
        else res = val_stk[val_n - 1];
      end
      if (err_code != ST_OK) res = 0;
      a.result = res[31:0];
      a.status = err_code;
      expected_answers.push_back(a);
      op_n = 0;
      val_n = 0;
      err_code = ST_OK;
      return;
    end
    if (err_code != ST_OK) return;
    case (t.kind)
      KIND_OPERAND: begin
        if (val_n >= DEPTH) raise_err(ST_OVER);
        else val_stk[val_n++] = longint'(signed'(t.value));
      end
      KIND_OPERATOR: begin
        while (err_code == ST_OK && op_n > 0 && op_stk[op_n - 1] != PAREN_MARK
               && op_stk[op_n - 1][2:1] >= {1'b0, t.op[1]})
          apply_operator();
        if (err_code == ST_OK) begin
          if (op_n >= DEPTH) raise_err(ST_OVER);
          else op_stk[op_n++] = {1'b0, t.op};
        end
      end
      KIND_LPAREN: begin
        if (op_n >= DEPTH) raise_err(ST_OVER);
        else op_stk[op_n++] = PAREN_MARK;
      end
      KIND_RPAREN: begin
        while (err_code == ST_OK && op_n > 0 && op_stk[op_n - 1] != PAREN_MARK)
          apply_operator();
        if (err_code == ST_OK) begin
          if (op_n == 0) raise_err(ST_UNDER);
          else op_n--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_token(logic [2:0] kind, logic [31:0] value, logic [1:0] op);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.op = op;
    pending_tokens.push_back(t);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      2: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      3: return 32'h0;
      default: return ($urandom_range(0, 20) - 10) << FRAC;
    endcase
  endfunction

  task automatic build_subexpr(int nest);
    int terms;
    terms = $urandom_range(1, 3);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_token(KIND_OPERATOR, $urandom, 2'($urandom_range(0, 3)));
      if (nest > 0 && $urandom_range(0, 3) == 0) begin
        add_token(KIND_LPAREN, $urandom, 2'($urandom));
        build_subexpr(nest - 1);
        add_token(KIND_RPAREN, $urandom, 2'($urandom));
      end else begin
        add_token(KIND_OPERAND, pick_value(), 2'($urandom));
      end
    end
  endtask

  task automatic build_expression();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      build_subexpr(2);
    end else if (r < 95) begin
      repeat ($urandom_range(1, 6))
        add_token(3'($urandom_range(0, 7)), $urandom, 2'($urandom));
    end else begin
      repeat ($urandom_range(8, 10))
        add_token(KIND_OPERAND, pick_value(), 2'($urandom));
    end
    add_token(KIND_END, $urandom, 2'($urandom));
  endtask

  function automatic int idle_pct(bit sender);
    case ((n_accepted / 240) % 4)
      0: return 0;
      1: return sender ? 75 : 0;
      2: return sender ? 0 : 75;
      default: return 19;
    endcase
  endfunction

  always @(posedge clk) begin
    token_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        t = pending_tokens.pop_front();
        evaluate_token(t);
        n_accepted++;
      end
      if (in_tvalid && !in_tready) begin
      end else if (pending_tokens.size() > 0 && $urandom_range(0, 99) >= idle_pct(1)) begin
        t = pending_tokens[0];
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, t.op, t.value, t.kind};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result: result=%h status=%0d", out_tdata[31:0],
                 out_tdata[33:32]);
          n_errors++;
        end else begin
          a = expected_answers.pop_front();
          if (out_tdata[31:0] !== a.result) begin
            $error("result: expected %h, actual %h", a.result, out_tdata[31:0]);
            n_errors++;
          end
          if (out_tdata[33:32] !== a.status) begin
            $error("status: expected %0d, actual %0d", a.status, out_tdata[33:32]);
            n_errors++;
          end
        end
      end
      if (!hold_done && n_accepted >= 700) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_pct(0));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    // Saturating add; subtract, multiply and divide with parentheses; a zero operand
    // followed by an extra one after a divide; unmatched parens, empty and extra operands.
    add_token(KIND_OPERAND, 32'h7fffffff, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_ADD);
    add_token(KIND_OPERAND, 32'h7fffffff, OP_ADD);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_LPAREN, 32'h0, OP_ADD);
    add_token(KIND_OPERAND, 32'h80000000, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_SUB);
    add_token(KIND_OPERAND, 32'h00010000, OP_ADD);
    add_token(KIND_RPAREN, 32'h0, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_MUL);
    add_token(KIND_OPERAND, 32'h00020000, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_DIV);
    add_token(KIND_OPERAND, 32'hfffd0000, OP_ADD);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_OPERAND, 32'h00050000, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_DIV);
    add_token(KIND_OPERAND, 32'h0, OP_ADD);
    add_token(KIND_OPERAND, 32'h1, OP_ADD);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_RPAREN, 32'h0, OP_ADD);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_LPAREN, 32'h0, OP_ADD);
    add_token(KIND_OPERAND, 32'h00010000, OP_ADD);
    add_token(KIND_OPERAND, 32'hffffffff, OP_ADD);
    add_token(3'd7, 32'hffffffff, OP_DIV);
    add_token(KIND_END, 32'h0, OP_ADD);
    add_token(KIND_OPERATOR, 32'h0, OP_SUB);
    add_token(KIND_END, 32'h0, OP_ADD);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_tokens.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    while (pending_tokens.size() < 1920) build_expression();
    while (pending_tokens.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0 && expected_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
